// ----- rtl/slpq_pkg.sv -----
// shared types and sizing constants for the sorted list priority queue
// no dependencies; imported by the top level, the checker and the testbench
package slpq_pkg;

  localparam int CAPACITY     = 16;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 16;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ENTRY_W = KEY_BITS + PAYLOAD_BITS;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_CMP,
    S_PUSH_HEAD,
    S_POP_HEAD,
    S_POP_SHIFT
  } state_t;

endpackage

// ----- rtl/slpq_ram.sv -----
// generic simple dual port ram: one write port, one read port, registered read
// no dependencies
module slpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ----- rtl/sorted_list_priority_queue.sv -----
// top level of the sorted list priority queue: sequencer, key compare and entry store
// depends on slpq_pkg and slpq_ram
//
// Entries sit in one ram in ascending key order, head at address 0. A request is
// taken when start is high and busy is low; its result appears on the out_ ports for
// exactly one cycle with out_valid high and cannot be held off. A push to a full queue,
// a pop of an empty queue and a push to an empty queue return their result in the
// cycle after the request with busy staying low. A push to a non-empty queue holds
// busy while the sequencer walks the ram from the tail one entry a cycle through its
// single read port, moving each larger entry (or, below the head, equal entry) up by
// one while comparing keys, until it reaches the new entry's slot. A pop holds busy
// while reading the head and moving every later entry down by one. The result
// strobe follows in the cycle busy drops, and a new request may be given in that cycle.
module sorted_list_priority_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_func,
  input  logic [slpq_pkg::KEY_BITS-1:0]      in_key,
  input  logic [slpq_pkg::PAYLOAD_BITS-1:0]  in_payload,
  output logic                               out_valid,
  output slpq_pkg::status_t                  out_status,
  output logic [slpq_pkg::KEY_BITS-1:0]      out_key,
  output logic [slpq_pkg::PAYLOAD_BITS-1:0]  out_payload,
  output logic [slpq_pkg::CNT_W-1:0]         out_fill
);

  import slpq_pkg::*;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [KEY_BITS-1:0]     key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;

  logic                    ovalid_r, ovalid_nxt;
  status_t                 ostatus_r, ostatus_nxt;
  logic [KEY_BITS-1:0]     okey_r, okey_nxt;
  logic [PAYLOAD_BITS-1:0] opay_r, opay_nxt;
  logic [CNT_W-1:0]        ofill_r, ofill_nxt;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]      ram_rdata;

  logic                    accept;
  logic [KEY_BITS-1:0]     rd_key;
  logic                    goes_after;
  logic                    idx_is_last;
  logic [IDX_W-1:0]        tail_idx;

  slpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // shared compare: the head only moves aside for a strictly larger key
  assign rd_key     = ram_rdata[ENTRY_W-1:PAYLOAD_BITS];
  assign goes_after = (idx_r == '0) ? (rd_key > key_r) : (rd_key >= key_r);

  assign idx_is_last = ({{(CNT_W-IDX_W){1'b0}}, idx_r} == (count_r - CNT_W'(1)));
  assign tail_idx    = IDX_W'(count_r - CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_func) begin
            if ((count_r != CAP_CNT) && (count_r != '0)) begin
              state_nxt = S_PUSH_CMP;
            end
          end else if (count_r != '0) begin
            state_nxt = S_POP_HEAD;
          end
        end
      end
      S_PUSH_CMP: begin
        if (!goes_after) begin
          state_nxt = S_IDLE;
        end else if (idx_r == '0) begin
          state_nxt = S_PUSH_HEAD;
        end
      end
      S_PUSH_HEAD: state_nxt = S_IDLE;
      S_POP_HEAD: begin
        if (count_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_POP_SHIFT;
        end
      end
      S_POP_SHIFT: begin
        if (idx_is_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    key_nxt     = key_r;
    pay_nxt     = pay_r;
    ovalid_nxt  = 1'b0;
    ostatus_nxt = ostatus_r;
    okey_nxt    = okey_r;
    opay_nxt    = opay_r;
    ofill_nxt   = ofill_r;
    ram_we      = 1'b0;
    ram_waddr   = idx_r + IDX_W'(1);
    ram_wdata   = ram_rdata;
    ram_raddr   = '0;

    unique case (state_r)
      S_IDLE: begin
        // pre-read the tail for a push, the head for a pop
        ram_raddr = in_func ? '0 : tail_idx;
        if (accept) begin
          key_nxt = in_key;
          pay_nxt = in_payload;
          idx_nxt = tail_idx;
          if (!in_func) begin
            if (count_r == CAP_CNT) begin
              ovalid_nxt  = 1'b1;
              ostatus_nxt = ST_FULL;
              okey_nxt    = '0;
              opay_nxt    = '0;
              ofill_nxt   = count_r;
            end else if (count_r == '0) begin
              ram_we      = 1'b1;
              ram_waddr   = '0;
              ram_wdata   = {in_key, in_payload};
              count_nxt   = CNT_W'(1);
              ovalid_nxt  = 1'b1;
              ostatus_nxt = ST_PUSHED;
              okey_nxt    = '0;
              opay_nxt    = '0;
              ofill_nxt   = CNT_W'(1);
            end
          end else if (count_r == '0) begin
            ovalid_nxt  = 1'b1;
            ostatus_nxt = ST_EMPTY;
            okey_nxt    = '0;
            opay_nxt    = '0;
            ofill_nxt   = '0;
          end
        end
      end
      S_PUSH_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r + IDX_W'(1);
        ram_raddr = idx_r - IDX_W'(1);
        if (goes_after) begin
          // move the larger entry up one slot and keep walking toward the head
          ram_wdata = ram_rdata;
          idx_nxt   = idx_r - IDX_W'(1);
        end else begin
          ram_wdata   = {key_r, pay_r};
          count_nxt   = count_r + CNT_W'(1);
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_PUSHED;
          okey_nxt    = '0;
          opay_nxt    = '0;
          ofill_nxt   = count_r + CNT_W'(1);
        end
      end
      S_PUSH_HEAD: begin
        ram_we      = 1'b1;
        ram_waddr   = '0;
        ram_wdata   = {key_r, pay_r};
        count_nxt   = count_r + CNT_W'(1);
        ovalid_nxt  = 1'b1;
        ostatus_nxt = ST_PUSHED;
        okey_nxt    = '0;
        opay_nxt    = '0;
        ofill_nxt   = count_r + CNT_W'(1);
      end
      S_POP_HEAD: begin
        okey_nxt  = rd_key;
        opay_nxt  = ram_rdata[PAYLOAD_BITS-1:0];
        idx_nxt   = IDX_W'(1);
        ram_raddr = IDX_W'(1);
        if (count_r == CNT_W'(1)) begin
          count_nxt   = '0;
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_POPPED;
          ofill_nxt   = '0;
        end
      end
      S_POP_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r - IDX_W'(1);
        ram_wdata = ram_rdata;
        ram_raddr = idx_r + IDX_W'(1);
        idx_nxt   = idx_r + IDX_W'(1);
        if (idx_is_last) begin
          count_nxt   = count_r - CNT_W'(1);
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_POPPED;
          ofill_nxt   = count_r - CNT_W'(1);
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    key_r     <= key_nxt;
    pay_r     <= pay_nxt;
    ostatus_r <= ostatus_nxt;
    okey_r    <= okey_nxt;
    opay_r    <= opay_nxt;
    ofill_r   <= ofill_nxt;
  end

  assign out_valid   = ovalid_r;
  assign out_status  = ostatus_r;
  assign out_key     = okey_r;
  assign out_payload = opay_r;
  assign out_fill    = ofill_r;

endmodule

// ----- rtl/slpq_checker.sv -----
// port level checks for the sorted list priority queue, bound to the top level
// depends on slpq_pkg and sorted_list_priority_queue
module slpq_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input slpq_pkg::status_t                  out_status,
  input logic [slpq_pkg::KEY_BITS-1:0]      out_key,
  input logic [slpq_pkg::PAYLOAD_BITS-1:0]  out_payload,
  input logic [slpq_pkg::CNT_W-1:0]         out_fill
);

  import slpq_pkg::*;

  // every request either starts a walk or answers at once
  a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("request neither started work nor returned a result");

  // the end of a walk always delivers its result
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_POPPED)) |-> ((out_key == '0) && (out_payload == '0)))
    else $error("non-pop result carries key or payload");

  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_fill == '0))
    else $error("empty pop reports entries held");

  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_fill == CAP_CNT))
    else $error("dropped push with queue not full");

endmodule

bind sorted_list_priority_queue slpq_checker u_slpq_checker (.*);

// ----- dv/sorted_list_priority_queue_test.sv -----
// testbench for the sorted list priority queue: directed and random push/pop requests,
// every result checked against a behavioral copy of the queue kept here
// depends on slpq_pkg and the sorted_list_priority_queue rtl
module sorted_list_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import slpq_pkg::*;

  localparam logic FUNC_PUSH       = 1'b0;
  localparam logic FUNC_POP        = 1'b1;
  localparam int   STALL_LIMIT     = 2000;
  localparam int   RANDOM_REQUESTS = 830;
  localparam int   DRAIN_CYCLES    = 24;

  typedef struct packed {
    status_t                 status;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [CNT_W-1:0]        fill;
  } pq_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    in_func = 1'b0;
  logic [KEY_BITS-1:0]     in_key = '0;
  logic [PAYLOAD_BITS-1:0] in_payload = '0;
  logic                    busy;
  logic                    out_valid;
  status_t                 out_status;
  logic [KEY_BITS-1:0]     out_key;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [CNT_W-1:0]        out_fill;

  // behavioral copy of the queue, head at index 0
  logic [KEY_BITS-1:0]     held_keys [CAPACITY];
  logic [PAYLOAD_BITS-1:0] held_payloads [CAPACITY];
  int                      held_count = 0;
  pq_result_t              awaited_results [$];

  int  mismatches = 0;
  int  requests_sent = 0;
  int  results_seen = 0;
  int  stall_cycles = 0;
  int  status_seen [4] = '{default: 0};
  bit  idle_off = 1'b0;

  sorted_list_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_func    (in_func),
    .in_key     (in_key),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_key    (out_key),
    .out_payload(out_payload),
    .out_fill   (out_fill)
  );

  always #5 clk = ~clk;

  // applies one request to the queue copy and returns the result it must produce
  function automatic pq_result_t apply_queue_request(logic func, logic [KEY_BITS-1:0] key,
                                                     logic [PAYLOAD_BITS-1:0] pay);
    pq_result_t r;
    int         slot;
    r = '{status: ST_PUSHED, key: '0, payload: '0, fill: '0};
    if (func == FUNC_PUSH) begin
      if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // head is only displaced by a strictly smaller key
        slot = held_count;
        if (held_count == 0 || held_keys[0] > key) begin
          slot = 0;
        end else begin
          for (int i = 1; i < held_count; i++) begin
            if (held_keys[i] >= key) begin
              slot = i;
              break;
            end
          end
        end
        for (int i = held_count; i > slot; i--) begin
          held_keys[i]     = held_keys[i-1];
          held_payloads[i] = held_payloads[i-1];
        end
        held_keys[slot]     = key;
        held_payloads[slot] = pay;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status  = ST_POPPED;
        r.key     = held_keys[0];
        r.payload = held_payloads[0];
        for (int i = 1; i < held_count; i++) begin
          held_keys[i-1]     = held_keys[i];
          held_payloads[i-1] = held_payloads[i];
        end
        held_count--;
      end
    end
    r.fill = CNT_W'(held_count);
    return r;
  endfunction

  // result check, request capture and stall watchdog, all on pre-edge values
  always @(posedge clk) begin
    pq_result_t want;
    bit         taken;
    taken = 1'b0;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d key %h payload %h fill %0d",
                     out_status, out_key, out_payload, out_fill);
        end else begin
          want = awaited_results.pop_front();
          status_seen[want.status]++;
          if (out_status !== want.status || out_key !== want.key ||
              out_payload !== want.payload || out_fill !== want.fill) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result %0d mismatch: expected status %0d key %h payload %h fill %0d,",
                        " got status %0d key %h payload %h fill %0d"},
                       results_seen, want.status, want.key, want.payload, want.fill,
                       out_status, out_key, out_payload, out_fill);
          end
        end
      end
      if (start && busy === 1'b0) begin
        awaited_results.push_back(apply_queue_request(in_func, in_key, in_payload));
        taken = 1'b1;
      end
      if (taken || out_valid === 1'b1) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("no request or result moved for %0d cycles", STALL_LIMIT);
          $display("sorted_list_priority_queue_test NOT OK");
          $finish;
        end
      end
    end
  end

  // drives one request after a random gap (none while idle_off is set) and returns at the edge that takes it
  task automatic send_request(input logic func, input logic [KEY_BITS-1:0] key,
                              input logic [PAYLOAD_BITS-1:0] pay);
    int unsigned gap;
    gap = idle_off ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_func    <= func;
    in_key     <= key;
    in_payload <= pay;
    do @(posedge clk); while (busy !== 1'b0);
    requests_sent++;
  endtask

  task automatic test_empty_pop();
    send_request(FUNC_POP, '0, '0);
    send_request(FUNC_POP, '1, '1);
  endtask

  // smaller key takes the head, equal-to-head keys go right behind it
  task automatic test_head_insertion();
    send_request(FUNC_PUSH, 32'd100, 16'd1);
    send_request(FUNC_PUSH, 32'd50, 16'd2);
    send_request(FUNC_PUSH, 32'd50, 16'd3);
    send_request(FUNC_PUSH, 32'd50, 16'd4);
    send_request(FUNC_PUSH, 32'd0, 16'h0000);
    send_request(FUNC_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(FUNC_PUSH, 32'd75, 16'd6);
    // unsigned order across the sign bit
    send_request(FUNC_PUSH, 32'h8000_0000, 16'h8000);
    send_request(FUNC_PUSH, 32'h7FFF_FFFF, 16'h7FFF);
  endtask

  task automatic test_fill_to_capacity();
    for (int i = 0; i < 7; i++)
      send_request(FUNC_PUSH, (i % 2 == 0) ? 32'hFFFF_FFFF : $urandom(), 16'(100 + i));
    send_request(FUNC_PUSH, 32'd1, 16'hABCD);
    repeat (3) send_request(FUNC_POP, $urandom(), 16'($urandom()));
  endtask

  // bursts with a push bias, a key style and an idle style of their own
  task automatic test_random_traffic();
    int                  burst_len;
    int                  push_pct;
    int                  key_style;
    int                  sent;
    logic [KEY_BITS-1:0] key;
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst_len = $urandom_range(10, 60);
      case ($urandom_range(0, 4))
        0:       push_pct = 10;
        1:       push_pct = 35;
        2:       push_pct = 50;
        3:       push_pct = 65;
        default: push_pct = 90;
      endcase
      key_style = $urandom_range(0, 3);
      idle_off  = ($urandom_range(0, 4) == 0);
      for (int n = 0; n < burst_len && sent < RANDOM_REQUESTS; n++) begin
        case (key_style)
          0: key = $urandom_range(0, 7);
          1: key = $urandom();
          2: begin
            case ($urandom_range(0, 3))
              0:       key = '0;
              1:       key = '1;
              2:       key = 32'h8000_0000;
              default: key = 32'h7FFF_FFFF;
            endcase
          end
          default: begin
            // land on or right next to the current head key
            if (held_count > 0)
              key = held_keys[0] + KEY_BITS'($urandom_range(0, 2)) - KEY_BITS'(1);
            else
              key = $urandom();
          end
        endcase
        send_request(($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP, key,
                     16'($urandom()));
        sent++;
      end
    end
    idle_off = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_pop();
    test_head_insertion();
    test_fill_to_capacity();
    test_random_traffic();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d requests, checked %0d results, %0d mismatches",
             requests_sent, results_seen, mismatches);
    $display("pushed %0d, popped %0d, pop on empty %0d, dropped on full %0d",
             status_seen[ST_PUSHED], status_seen[ST_POPPED], status_seen[ST_EMPTY],
             status_seen[ST_FULL]);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("sorted_list_priority_queue_test OK");
    end else begin
      $display("sorted_list_priority_queue_test NOT OK");
    end
    $finish;
  end

endmodule
